// File: rtl/aavr_pkg.sv
// Shared types, constants and the arctangent table of the axis-angle rotation pipeline.
// No dependencies; every other file of the block imports this package.
package aavr_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 20;
  localparam int Q30          = 30;
  localparam int WORD_W       = 32;
  localparam int CW           = 34;
  localparam int TOL_W        = 16;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [2:0]              vec3_t;
  typedef logic signed [CW-1:0]     cw_t;

  typedef struct packed {
    vec3_t v;
    vec3_t k;
    word_t angle;
  } item_t;

  typedef struct packed {
    cw_t c;
    cw_t s;
  } trig_t;

  // angle reduction modulo one turn
  localparam longint MOD_TURN   = longint'(360) << FRAC_BITS;
  localparam longint MOD_OFFSET = ((longint'(1) << (WORD_W - 1)) / MOD_TURN + 1) * MOD_TURN;
  localparam int     MOD_STEPS  = $clog2(2 * (MOD_OFFSET / MOD_TURN));
  localparam int     ACC_W      = WORD_W + 2;
  localparam int     REM_W      = $clog2(MOD_TURN);

  // degrees to binary angle: divide by 360 as a shift by 3 and a reciprocal multiply by 45
  localparam int     DEG_TURN  = 360;
  localparam int     DEG_W     = $clog2(DEG_TURN);
  localparam int     DEG_SHIFT = 3;
  localparam int     DEG_ODD   = DEG_TURN >> DEG_SHIFT;
  localparam int     X_W       = $clog2(longint'(DEG_TURN) << (WORD_W - FRAC_BITS));
  localparam int     DIVD_W    = (REM_W > X_W) ? REM_W : X_W;
  localparam int     RCP_IN_W  = DIVD_W - DEG_SHIFT;
  localparam int     RCP_SHIFT = RCP_IN_W + $clog2(DEG_ODD);
  localparam longint RCP       = ((longint'(1) << RCP_SHIFT) + DEG_ODD - 1) / DEG_ODD;
  localparam int     RCP_W     = $clog2(RCP + 1);

  // axis length and unit axis
  localparam int SQ_W       = 2 * WORD_W;
  localparam int ROOT_STEPS = WORD_W;
  localparam int Q_STEPS    = Q30 + 1;

  localparam longint CORDIC_X0 = 652032874;
  localparam longint RND       = longint'(1) << (Q30 - 1);

  function automatic logic [DIVD_W-1:0] div_deg(input logic [DIVD_W-1:0] n);
    logic [RCP_IN_W+RCP_W-1:0] p;
    p = n[DIVD_W-1:DEG_SHIFT] * RCP_W'(RCP);
    return DIVD_W'(p >> RCP_SHIFT);
  endfunction

  function automatic cw_t atan_q30(input int i);
    cw_t r;
    case (i)
      0:  r = CW'(536870912);
      1:  r = CW'(316933406);
      2:  r = CW'(167458907);
      3:  r = CW'(85004756);
      4:  r = CW'(42667331);
      5:  r = CW'(21354465);
      6:  r = CW'(10679838);
      7:  r = CW'(5340245);
      8:  r = CW'(2670163);
      9:  r = CW'(1335087);
      10: r = CW'(667544);
      11: r = CW'(333772);
      12: r = CW'(166886);
      13: r = CW'(83443);
      14: r = CW'(41722);
      15: r = CW'(20861);
      16: r = CW'(10430);
      17: r = CW'(5215);
      18: r = CW'(2608);
      19: r = CW'(1304);
      20: r = CW'(652);
      21: r = CW'(326);
      22: r = CW'(163);
      23: r = CW'(81);
      24: r = CW'(41);
      25: r = CW'(20);
      26: r = CW'(10);
      27: r = CW'(5);
      28: r = CW'(3);
      29: r = CW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/aavr_sincos.sv
// Sine and cosine pipeline: angle reduction, degree to binary angle division, CORDIC.
// Depends on aavr_pkg.
module aavr_sincos import aavr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o,
  output trig_t trig_o
);

  localparam cw_t QUARTER = CW'(longint'(1) << (WORD_W - 2));
  localparam cw_t HALF    = CW'(longint'(1) << (WORD_W - 1));
  localparam int  Q1_W    = WORD_W - FRAC_BITS;

  logic [MOD_STEPS-1:0] mod_vld_q;
  item_t                mod_item_q [MOD_STEPS];
  logic [ACC_W-1:0]     mod_acc_q  [MOD_STEPS];

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    localparam logic [ACC_W-1:0] SUB = ACC_W'(MOD_TURN << (MOD_STEPS - 1 - j));
    logic             vld_in;
    item_t            item_in;
    logic [ACC_W-1:0] acc_in;
    if (j == 0) begin : g_src
      assign vld_in  = valid_i;
      assign item_in = item_i;
      assign acc_in  = ACC_W'($signed(item_i.angle)) + ACC_W'(MOD_OFFSET);
    end else begin : g_src
      assign vld_in  = mod_vld_q[j-1];
      assign item_in = mod_item_q[j-1];
      assign acc_in  = mod_acc_q[j-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mod_vld_q[j] <= 1'b0;
      end else if (en_i) begin
        mod_vld_q[j] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mod_item_q[j] <= item_in;
        mod_acc_q[j]  <= (acc_in >= SUB) ? acc_in - SUB : acc_in;
      end
    end
  end

  // upper quotient: whole binary-angle steps of the reduced angle
  logic                 dq_vld_q;
  item_t                dq_item_q;
  logic [DIVD_W-1:0]    dq_r_q;
  logic [FRAC_BITS-1:0] dq_q0_q;
  logic [DIVD_W-1:0]    r_s;

  assign r_s = DIVD_W'(mod_acc_q[MOD_STEPS-1][REM_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_vld_q <= 1'b0;
    end else if (en_i) begin
      dq_vld_q <= mod_vld_q[MOD_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dq_item_q <= mod_item_q[MOD_STEPS-1];
      dq_r_q    <= r_s;
      dq_q0_q   <= FRAC_BITS'(div_deg(r_s));
    end
  end

  // remainder, scaled and rounded
  logic                 dr_vld_q;
  item_t                dr_item_q;
  logic [FRAC_BITS-1:0] dr_q0_q;
  logic [DIVD_W-1:0]    dr_x2_q;
  logic [DIVD_W-1:0]    rem0_s, x2_s;

  assign rem0_s = dq_r_q - DIVD_W'(dq_q0_q) * DIVD_W'(DEG_TURN);
  assign x2_s   = (DIVD_W'(rem0_s[DEG_W-1:0]) << Q1_W) + DIVD_W'(DEG_TURN / 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dr_vld_q <= 1'b0;
    end else if (en_i) begin
      dr_vld_q <= dq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dr_item_q <= dq_item_q;
      dr_q0_q   <= dq_q0_q;
      dr_x2_q   <= x2_s;
    end
  end

  // lower quotient and binary angle
  logic              db_vld_q;
  item_t             db_item_q;
  logic [WORD_W-1:0] db_bam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_vld_q <= 1'b0;
    end else if (en_i) begin
      db_vld_q <= dr_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      db_item_q <= dr_item_q;
      db_bam_q  <= {dr_q0_q, Q1_W'(div_deg(dr_x2_q))};
    end
  end

  // fold by half a turn
  logic  fold_vld_q, fold_neg_q, fold_neg_d;
  item_t fold_item_q;
  cw_t   fold_z_q, fold_z_d, bam_s;

  assign bam_s = CW'($signed(db_bam_q));

  always_comb begin
    fold_z_d   = bam_s;
    fold_neg_d = 1'b0;
    if (bam_s > QUARTER) begin
      fold_z_d   = bam_s - HALF;
      fold_neg_d = 1'b1;
    end else if (bam_s < -QUARTER) begin
      fold_z_d   = bam_s + HALF;
      fold_neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_vld_q <= 1'b0;
    end else if (en_i) begin
      fold_vld_q <= db_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_item_q <= db_item_q;
      fold_z_q    <= fold_z_d;
      fold_neg_q  <= fold_neg_d;
    end
  end

  logic [CORDIC_STEPS-1:0] cor_vld_q, cor_neg_q;
  item_t                   cor_item_q [CORDIC_STEPS];
  cw_t                     cor_x_q    [CORDIC_STEPS];
  cw_t                     cor_y_q    [CORDIC_STEPS];
  cw_t                     cor_z_q    [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
    localparam cw_t ATAN = atan_q30(i);
    logic  vld_in, neg_in;
    item_t item_in;
    cw_t   x_in, y_in, z_in, dx, dy;
    if (i == 0) begin : g_src
      assign vld_in  = fold_vld_q;
      assign neg_in  = fold_neg_q;
      assign item_in = fold_item_q;
      assign x_in    = CW'(CORDIC_X0);
      assign y_in    = '0;
      assign z_in    = fold_z_q;
    end else begin : g_src
      assign vld_in  = cor_vld_q[i-1];
      assign neg_in  = cor_neg_q[i-1];
      assign item_in = cor_item_q[i-1];
      assign x_in    = cor_x_q[i-1];
      assign y_in    = cor_y_q[i-1];
      assign z_in    = cor_z_q[i-1];
    end
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cor_vld_q[i] <= 1'b0;
      end else if (en_i) begin
        cor_vld_q[i] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cor_item_q[i] <= item_in;
        cor_neg_q[i]  <= neg_in;
        if (!z_in[CW-1]) begin
          cor_x_q[i] <= x_in - dx;
          cor_y_q[i] <= y_in + dy;
          cor_z_q[i] <= z_in - ATAN;
        end else begin
          cor_x_q[i] <= x_in + dx;
          cor_y_q[i] <= y_in - dy;
          cor_z_q[i] <= z_in + ATAN;
        end
      end
    end
  end

  logic  vld_q;
  item_t item_q;
  trig_t trig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cor_vld_q[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q   <= cor_item_q[CORDIC_STEPS-1];
      trig_q.c <= cor_neg_q[CORDIC_STEPS-1] ? -cor_x_q[CORDIC_STEPS-1]
                                            : cor_x_q[CORDIC_STEPS-1];
      trig_q.s <= cor_neg_q[CORDIC_STEPS-1] ? -cor_y_q[CORDIC_STEPS-1]
                                            : cor_y_q[CORDIC_STEPS-1];
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;
  assign trig_o  = trig_q;

endmodule

// File: rtl/aavr_axis_norm.sv
// Axis normalisation pipeline: squared length, bit-serial square root, unit axis division.
// Depends on aavr_pkg.
module aavr_axis_norm import aavr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [TOL_W-1:0] tol_i,
  input  logic             valid_i,
  input  item_t            item_i,
  input  trig_t            trig_i,
  output logic             valid_o,
  output item_t            item_o,
  output trig_t            trig_o,
  output vec3_t            unit_o
);

  // squares
  logic                  sqr_vld_q;
  item_t                 sqr_item_q;
  trig_t                 sqr_trig_q;
  logic signed [SQ_W-1:0] sqr_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqr_vld_q <= 1'b0;
    end else if (en_i) begin
      sqr_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqr_item_q <= item_i;
      sqr_trig_q <= trig_i;
      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= $signed(item_i.k[i]) * $signed(item_i.k[i]);
      end
    end
  end

  // sum of squares
  logic            sum_vld_q;
  item_t           sum_item_q;
  trig_t           sum_trig_q;
  logic [SQ_W-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else if (en_i) begin
      sum_vld_q <= sqr_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_item_q <= sqr_item_q;
      sum_trig_q <= sqr_trig_q;
      sum_q      <= SQ_W'(sqr_q[0]) + SQ_W'(sqr_q[1]) + SQ_W'(sqr_q[2]);
    end
  end

  // square root, one result bit a stage
  logic [ROOT_STEPS-1:0] rt_vld_q;
  item_t                 rt_item_q [ROOT_STEPS];
  trig_t                 rt_trig_q [ROOT_STEPS];
  logic [SQ_W-1:0]       rt_op_q   [ROOT_STEPS];
  logic [SQ_W-1:0]       rt_res_q  [ROOT_STEPS];

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
    localparam logic [SQ_W-1:0] ONE = SQ_W'(1) << (SQ_W - 2 - 2 * i);
    logic            vld_in;
    item_t           item_in;
    trig_t           trig_in;
    logic [SQ_W-1:0] op_in, res_in;
    logic [SQ_W:0]   trial;
    if (i == 0) begin : g_src
      assign vld_in  = sum_vld_q;
      assign item_in = sum_item_q;
      assign trig_in = sum_trig_q;
      assign op_in   = sum_q;
      assign res_in  = '0;
    end else begin : g_src
      assign vld_in  = rt_vld_q[i-1];
      assign item_in = rt_item_q[i-1];
      assign trig_in = rt_trig_q[i-1];
      assign op_in   = rt_op_q[i-1];
      assign res_in  = rt_res_q[i-1];
    end
    assign trial = {1'b0, res_in} + {1'b0, ONE};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_vld_q[i] <= 1'b0;
      end else if (en_i) begin
        rt_vld_q[i] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_item_q[i] <= item_in;
        rt_trig_q[i] <= trig_in;
        if ({1'b0, op_in} >= trial) begin
          rt_op_q[i]  <= op_in - trial[SQ_W-1:0];
          rt_res_q[i] <= (res_in >> 1) + ONE;
        end else begin
          rt_op_q[i]  <= op_in;
          rt_res_q[i] <= res_in >> 1;
        end
      end
    end
  end

  logic [WORD_W-1:0] mag_s;
  logic              near_s;

  assign mag_s  = rt_res_q[ROOT_STEPS-1][WORD_W-1:0];
  assign near_s = (mag_s == '0) || (mag_s < WORD_W'(tol_i));

  // unit axis: |k| * 2^30 / length, one quotient bit a stage on each lane
  logic [Q_STEPS-1:0]          dv_vld_q, dv_near_q;
  item_t                       dv_item_q [Q_STEPS];
  trig_t                       dv_trig_q [Q_STEPS];
  logic [WORD_W-1:0]           dv_mag_q  [Q_STEPS];
  logic [2:0][WORD_W:0]        dv_rem_q  [Q_STEPS];
  logic [2:0][Q30:0]           dv_quo_q  [Q_STEPS];

  for (genvar i = 0; i < Q_STEPS; i++) begin : g_div
    logic                 vld_in, near_in;
    item_t                item_in;
    trig_t                trig_in;
    logic [WORD_W-1:0]    mag_in;
    logic [2:0][WORD_W:0] t;
    logic [2:0][WORD_W:0] rem_d;
    logic [2:0][Q30:0]    quo_in, quo_d;
    if (i == 0) begin : g_src
      assign vld_in  = rt_vld_q[ROOT_STEPS-1];
      assign near_in = near_s;
      assign item_in = rt_item_q[ROOT_STEPS-1];
      assign trig_in = rt_trig_q[ROOT_STEPS-1];
      assign mag_in  = mag_s;
      assign quo_in  = '0;
      for (genvar l = 0; l < 3; l++) begin : g_abs
        assign t[l] = {1'b0, item_in.k[l][WORD_W-1] ? (~item_in.k[l] + WORD_W'(1))
                                                     : item_in.k[l]};
      end
    end else begin : g_src
      assign vld_in  = dv_vld_q[i-1];
      assign near_in = dv_near_q[i-1];
      assign item_in = dv_item_q[i-1];
      assign trig_in = dv_trig_q[i-1];
      assign mag_in  = dv_mag_q[i-1];
      assign quo_in  = dv_quo_q[i-1];
      for (genvar l = 0; l < 3; l++) begin : g_abs
        assign t[l] = {dv_rem_q[i-1][l][WORD_W-1:0], 1'b0};
      end
    end
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (t[l] >= {1'b0, mag_in}) begin
          rem_d[l] = t[l] - {1'b0, mag_in};
          quo_d[l] = {quo_in[l][Q30-1:0], 1'b1};
        end else begin
          rem_d[l] = t[l];
          quo_d[l] = {quo_in[l][Q30-1:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[i] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[i] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_near_q[i] <= near_in;
        dv_item_q[i] <= item_in;
        dv_trig_q[i] <= trig_in;
        dv_mag_q[i]  <= mag_in;
        dv_rem_q[i]  <= rem_d;
        dv_quo_q[i]  <= quo_d;
      end
    end
  end

  logic  vld_q;
  item_t item_q;
  trig_t trig_q;
  vec3_t unit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= dv_vld_q[Q_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [WORD_W-1:0] qs;
    if (en_i) begin
      item_q <= dv_item_q[Q_STEPS-1];
      trig_q <= dv_trig_q[Q_STEPS-1];
      for (int l = 0; l < 3; l++) begin
        qs = $signed({1'b0, dv_quo_q[Q_STEPS-1][l]});
        if (dv_near_q[Q_STEPS-1]) begin
          unit_q[l] <= $signed(dv_item_q[Q_STEPS-1].k[l]) <<< (Q30 - FRAC_BITS);
        end else if (dv_item_q[Q_STEPS-1].k[l][WORD_W-1]) begin
          unit_q[l] <= -qs;
        end else begin
          unit_q[l] <= qs;
        end
      end
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;
  assign trig_o  = trig_q;
  assign unit_o  = unit_q;

endmodule

// File: rtl/aavr_rodrigues.sv
// Rodrigues combination pipeline: dot and cross products, scaled terms, saturating sum.
// Depends on aavr_pkg.
module aavr_rodrigues import aavr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  vec3_t vec_i,
  input  vec3_t unit_i,
  input  trig_t trig_i,
  output logic  valid_o,
  output vec3_t rot_o,
  output logic  sat_o
);

  localparam logic signed [44:0] SMAX = 45'sd2147483647;
  localparam logic signed [44:0] SMIN = -45'sd2147483648;
  localparam logic signed [34:0] QONE = 35'(longint'(1) << Q30);

  // stage 1: products with the vector
  logic                s1_vld_q;
  logic signed [63:0]  s1_pd_q [3];
  logic signed [63:0]  s1_pa_q [3];
  logic signed [63:0]  s1_pb_q [3];
  logic signed [65:0]  s1_vc_q [3];
  vec3_t               s1_u_q;
  trig_t               s1_trig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_u_q    <= unit_i;
      s1_trig_q <= trig_i;
      for (int i = 0; i < 3; i++) begin
        s1_pd_q[i] <= $signed(unit_i[i]) * $signed(vec_i[i]);
        s1_pa_q[i] <= $signed(unit_i[(i+1)%3]) * $signed(vec_i[(i+2)%3]);
        s1_pb_q[i] <= $signed(unit_i[(i+2)%3]) * $signed(vec_i[(i+1)%3]);
        s1_vc_q[i] <= $signed(vec_i[i]) * trig_i.c;
      end
    end
  end

  // stage 2: dot product, cross product, cosine term, 1 - cos
  logic               s2_vld_q;
  logic signed [35:0] s2_d_q;
  logic signed [34:0] s2_cr_q [3];
  logic signed [35:0] s2_t1_q [3];
  logic signed [34:0] s2_w_q;
  vec3_t              s2_u_q;
  cw_t                s2_s_q;
  logic signed [65:0] dot_s;

  assign dot_s = s1_pd_q[0] + s1_pd_q[1] + s1_pd_q[2] + 66'(RND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [64:0] cr;
    logic signed [65:0] vc;
    if (en_i) begin
      s2_d_q <= dot_s[65:30];
      s2_w_q <= QONE - s1_trig_q.c;
      s2_u_q <= s1_u_q;
      s2_s_q <= s1_trig_q.s;
      for (int i = 0; i < 3; i++) begin
        cr         = s1_pa_q[i] - s1_pb_q[i] + 65'(RND);
        vc         = s1_vc_q[i] + 66'(RND);
        s2_cr_q[i] <= cr[64:30];
        s2_t1_q[i] <= vc[65:30];
      end
    end
  end

  // stage 3: axis times dot, cross times sine
  logic               s3_vld_q;
  logic signed [67:0] s3_ud_q  [3];
  logic signed [68:0] s3_crs_q [3];
  logic signed [35:0] s3_t1_q  [3];
  logic signed [34:0] s3_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_w_q <= s2_w_q;
      for (int i = 0; i < 3; i++) begin
        s3_ud_q[i]  <= $signed(s2_u_q[i]) * s2_d_q;
        s3_crs_q[i] <= s2_cr_q[i] * s2_s_q;
        s3_t1_q[i]  <= s2_t1_q[i];
      end
    end
  end

  // stage 4: round both products back to Q16.16
  logic               s4_vld_q;
  logic signed [37:0] s4_a_q  [3];
  logic signed [38:0] s4_t2_q [3];
  logic signed [35:0] s4_t1_q [3];
  logic signed [34:0] s4_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [67:0] ud;
    logic signed [68:0] crs;
    if (en_i) begin
      s4_w_q <= s3_w_q;
      for (int i = 0; i < 3; i++) begin
        ud         = s3_ud_q[i] + 68'(RND);
        crs        = s3_crs_q[i] + 69'(RND);
        s4_a_q[i]  <= ud[67:30];
        s4_t2_q[i] <= crs[68:30];
        s4_t1_q[i] <= s3_t1_q[i];
      end
    end
  end

  // stage 5: scale by 1 - cos
  logic               s5_vld_q;
  logic signed [72:0] s5_aw_q [3];
  logic signed [38:0] s5_t2_q [3];
  logic signed [35:0] s5_t1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en_i) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        s5_aw_q[i] <= s4_a_q[i] * s4_w_q;
        s5_t2_q[i] <= s4_t2_q[i];
        s5_t1_q[i] <= s4_t1_q[i];
      end
    end
  end

  // stage 6: sum and clip
  logic               vld_q, sat_q;
  vec3_t              rot_q;
  logic signed [44:0] sum_s [3];
  logic [2:0]         clip_s;

  always_comb begin
    logic signed [72:0] aw;
    for (int i = 0; i < 3; i++) begin
      aw        = s5_aw_q[i] + 73'(RND);
      sum_s[i]  = 45'(s5_t1_q[i]) + 45'(s5_t2_q[i]) + 45'($signed(aw[72:30]));
      clip_s[i] = (sum_s[i] > SMAX) || (sum_s[i] < SMIN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q <= |clip_s;
      for (int i = 0; i < 3; i++) begin
        if (sum_s[i] > SMAX) begin
          rot_q[i] <= SMAX[WORD_W-1:0];
        end else if (sum_s[i] < SMIN) begin
          rot_q[i] <= SMIN[WORD_W-1:0];
        end else begin
          rot_q[i] <= sum_s[i][WORD_W-1:0];
        end
      end
    end
  end

  assign valid_o = vld_q;
  assign rot_o   = rot_q;
  assign sat_o   = sat_q;

endmodule

// File: rtl/axis_angle_vector_rotation_unit.sv
// Axis-angle vector rotation unit: top level with the tolerance register and beat handshake.
// Depends on aavr_pkg, aavr_sincos, aavr_axis_norm and aavr_rodrigues.
//
// Rotates a Q16.16 vector about a Q16.16 axis by an angle in degrees (Rodrigues formula).
// One beat is taken every cycle unless the pipeline holds; one result beat leaves per
// input beat, in order. Each beat passes angle reduction, degree conversion and a 20-step
// CORDIC, then the squared length, a 32-stage square root, a 31-stage unit-axis division and
// its output register, and last the product and sum stages. The whole pipeline holds
// while the result register is full and not taken; the axis length tolerance is written
// through cfg_we_i.
module axis_angle_vector_rotation_unit import aavr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TOL_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] angle_deg_i,
  input  logic signed [31:0] axis_x_i,
  input  logic signed [31:0] axis_y_i,
  input  logic signed [31:0] axis_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] rot_x_o,
  output logic signed [31:0] rot_y_o,
  output logic signed [31:0] rot_z_o,
  output logic               saturated_o
);

  logic [TOL_W-1:0] tol_q;
  logic             en;
  item_t            item_in;
  logic             sc_vld, nm_vld, rd_vld;
  item_t            sc_item, nm_item;
  trig_t            sc_trig, nm_trig;
  vec3_t            nm_unit, rot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(7);
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  assign en         = !rd_vld || out_ready_i;
  assign in_ready_o = en;

  assign item_in.v     = {vec_z_i, vec_y_i, vec_x_i};
  assign item_in.k     = {axis_z_i, axis_y_i, axis_x_i};
  assign item_in.angle = angle_deg_i;

  aavr_sincos u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (item_in),
    .valid_o (sc_vld),
    .item_o  (sc_item),
    .trig_o  (sc_trig)
  );

  aavr_axis_norm u_axis_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tol_i   (tol_q),
    .valid_i (sc_vld),
    .item_i  (sc_item),
    .trig_i  (sc_trig),
    .valid_o (nm_vld),
    .item_o  (nm_item),
    .trig_o  (nm_trig),
    .unit_o  (nm_unit)
  );

  aavr_rodrigues u_rodrigues (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_vld),
    .vec_i   (nm_item.v),
    .unit_i  (nm_unit),
    .trig_i  (nm_trig),
    .valid_o (rd_vld),
    .rot_o   (rot),
    .sat_o   (saturated_o)
  );

  assign out_valid_o = rd_vld;
  assign rot_x_o     = rot[0];
  assign rot_y_o     = rot[1];
  assign rot_z_o     = rot[2];

endmodule
